### rtl/sc2hid_pkg.sv
// ----------------------------------------------------------------------------
// sc2hid_pkg
// Shared types, constants and lookup functions for the set-1 scan code to
// HID boot keyboard report converter.
// ----------------------------------------------------------------------------
package sc2hid_pkg;

   // Default slot count and number of slots shown on the result channel
   localparam int KEY_SLOTS_DEFAULT = 6;
   localparam int OUT_SLOTS         = 6;

   localparam logic [7:0] REPORT_ID_RESET = 8'h01;
   localparam logic [7:0] SENT_MOD_RESET  = 8'hFF;

   // Input commands
   localparam logic CMD_KEY         = 1'b0;
   localparam logic CMD_RELEASE_ALL = 1'b1;

   // Result status codes
   localparam logic STATUS_OK          = 1'b0;
   localparam logic STATUS_UNSUPPORTED = 1'b1;

   // Set-1 make codes of the modifier keys
   localparam logic [7:0] SC_CTRL   = 8'h1D;
   localparam logic [7:0] SC_LSHIFT = 8'h2A;
   localparam logic [7:0] SC_ALT    = 8'h38;
   localparam logic [7:0] SC_RSHIFT = 8'h36;
   localparam logic [7:0] SC_LWIN   = 8'h5B;
   localparam logic [7:0] SC_RWIN   = 8'h5C;

   // Modifier byte bits
   localparam logic [7:0] MB_LCTRL  = 8'h01;
   localparam logic [7:0] MB_LSHIFT = 8'h02;
   localparam logic [7:0] MB_LALT   = 8'h04;
   localparam logic [7:0] MB_LWIN   = 8'h08;
   localparam logic [7:0] MB_RCTRL  = 8'h10;
   localparam logic [7:0] MB_RSHIFT = 8'h20;
   localparam logic [7:0] MB_RALT   = 8'h40;
   localparam logic [7:0] MB_RWIN   = 8'h80;

   // HID usages of plain (non-E0) make codes 0x00..0x7F
   localparam logic [7:0] PLAIN_MAP [128] = '{
      8'h00, 8'h29, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23,
      8'h24, 8'h25, 8'h26, 8'h27, 8'h2D, 8'h2E, 8'h2A, 8'h2B,
      8'h14, 8'h1A, 8'h08, 8'h15, 8'h17, 8'h1C, 8'h18, 8'h0C,
      8'h12, 8'h13, 8'h2F, 8'h30, 8'h28, 8'h00, 8'h04, 8'h16,
      8'h07, 8'h09, 8'h0A, 8'h0B, 8'h0D, 8'h0E, 8'h0F, 8'h33,
      8'h34, 8'h35, 8'h00, 8'h31, 8'h1D, 8'h1B, 8'h06, 8'h19,
      8'h05, 8'h11, 8'h10, 8'h36, 8'h37, 8'h38, 8'h00, 8'h55,
      8'h00, 8'h2C, 8'h39, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E,
      8'h3F, 8'h40, 8'h41, 8'h42, 8'h43, 8'h53, 8'h47, 8'h5F,
      8'h60, 8'h61, 8'h56, 8'h5C, 8'h5D, 8'h5E, 8'h57, 8'h59,
      8'h5A, 8'h5B, 8'h62, 8'h63, 8'h00, 8'h00, 8'h00, 8'h44,
      8'h45, 8'h00, 8'h00, 8'h00, 8'h46, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_APPLY,
      ST_REPORT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic lookup;
      logic apply;
      logic report;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_free;
   } dp_sts_type;

   function automatic logic [7:0] mod_bit(input logic [7:0] code, input logic ext);
      logic [7:0] m;
      m = 8'h00;
      if (!ext) begin
         case (code)
            SC_CTRL:   m = MB_LCTRL;
            SC_LSHIFT: m = MB_LSHIFT;
            SC_ALT:    m = MB_LALT;
            SC_RSHIFT: m = MB_RSHIFT;
            default:   m = 8'h00;
         endcase
      end else begin
         case (code)
            SC_CTRL: m = MB_RCTRL;
            SC_ALT:  m = MB_RALT;
            SC_LWIN: m = MB_LWIN;
            SC_RWIN: m = MB_RWIN;
            default: m = 8'h00;
         endcase
      end
      return m;
   endfunction

   function automatic logic [7:0] usage_of(input logic [7:0] code, input logic ext);
      logic [7:0] u;
      u = 8'h00;
      if (ext) begin
         case (code)
            8'h48:   u = 8'h52;
            8'h50:   u = 8'h51;
            8'h4B:   u = 8'h50;
            8'h4D:   u = 8'h4F;
            8'h47:   u = 8'h4A;
            8'h4F:   u = 8'h4D;
            8'h49:   u = 8'h4B;
            8'h51:   u = 8'h4E;
            8'h52:   u = 8'h49;
            8'h53:   u = 8'h4C;
            8'h35:   u = 8'h54;
            8'h1C:   u = 8'h58;
            8'h37:   u = 8'h46;
            8'h5D:   u = 8'h65;
            8'h46:   u = 8'h48;
            default: u = 8'h00;
         endcase
      end else if (!code[7]) begin
         u = PLAIN_MAP[code[6:0]];
      end
      return u;
   endfunction

endpackage

### rtl/sc2hid_ctrl.sv
// ----------------------------------------------------------------------------
// sc2hid_ctrl
// Sequencer: accept one item, then step it through lookup, slot update and
// report stages of the datapath.
// ----------------------------------------------------------------------------
module sc2hid_ctrl
   import sc2hid_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ST_APPLY;
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = ST_REPORT;
         end
         ST_REPORT: begin
            // hold until the output register can take the result
            if (sts.out_free) begin
               cmd.report = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_capture_leads_lookup: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_LOOKUP))
      else $error("accepted item did not advance to lookup");

   a_report_only_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.report |-> sts.out_free)
      else $error("report issued while output register busy");

endmodule

### rtl/sc2hid_dpath.sv
// ----------------------------------------------------------------------------
// sc2hid_dpath
// Input capture, code lookup, modifier byte, compacted key slots, last-sent
// copy and the output register.
// ----------------------------------------------------------------------------
module sc2hid_dpath
   import sc2hid_pkg::*;
#(
   parameter int KEY_SLOTS = KEY_SLOTS_DEFAULT
)
(
   input  logic       clock,
   input  logic       reset,
   input  dp_cmd_type cmd,
   output dp_sts_type sts,
   input  logic       req_cmd,
   input  logic [7:0] req_scan_code,
   input  logic       req_is_extended,
   input  logic       req_is_down,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_status,
   output logic       rsp_report_valid,
   output logic [7:0] rsp_modifier_bits,
   output logic [7:0] rsp_key_slots [OUT_SLOTS]
);

   localparam int CW = $clog2(KEY_SLOTS + 1);

   // captured item
   logic       cmd_ff;
   logic [7:0] code_ff;
   logic       ext_ff;
   logic       down_ff;

   // lookup results
   logic [7:0] mod_mask_ff;
   logic [7:0] usage_ff;
   logic       err_ff;

   // key state
   logic [7:0]    modifier_ff;
   logic [7:0]    modifier_in;
   logic [7:0]    slot_ff [KEY_SLOTS];
   logic [7:0]    slot_in [KEY_SLOTS];
   logic [7:0]    slot_above [KEY_SLOTS];
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic [7:0]    sent_mod_ff;
   logic [7:0]    sent_slot_ff [KEY_SLOTS];

   // output register
   logic       rsp_valid_ff;
   logic       rsp_status_ff;
   logic       rsp_report_ff;
   logic [7:0] rsp_mod_ff;
   logic [7:0] rsp_slot_ff [OUT_SLOTS];

   logic [KEY_SLOTS-1:0] hit;
   logic [KEY_SLOTS-1:0] at_or_above;
   logic                 held;
   logic                 full;
   logic                 differs;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff  <= req_cmd;
         code_ff <= req_scan_code;
         ext_ff  <= req_is_extended;
         down_ff <= req_is_down;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         mod_mask_ff <= mod_bit(code_ff, ext_ff);
         usage_ff    <= usage_of(code_ff, ext_ff);
         err_ff      <= (cmd_ff == CMD_KEY) && (mod_bit(code_ff, ext_ff) == 8'h00)
                        && (usage_of(code_ff, ext_ff) == 8'h00);
      end
   end

   for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_above
      if (g < KEY_SLOTS - 1) begin : g_next
         assign slot_above[g] = slot_ff[g + 1];
      end else begin : g_top
         assign slot_above[g] = 8'h00;
      end
   end

   always_comb begin
      logic seen;
      seen = 1'b0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         hit[i]         = (slot_ff[i] == usage_ff);
         seen           = seen | hit[i];
         at_or_above[i] = seen;
      end
   end

   assign held = |hit;
   assign full = (count_ff == CW'(KEY_SLOTS));

   // next key state for the item in hand
   always_comb begin
      modifier_in = modifier_ff;
      slot_in     = slot_ff;
      count_in    = count_ff;
      if (cmd_ff == CMD_RELEASE_ALL) begin
         modifier_in = 8'h00;
         for (int i = 0; i < KEY_SLOTS; i++) begin
            slot_in[i] = 8'h00;
         end
         count_in = '0;
      end else if (mod_mask_ff != 8'h00) begin
         modifier_in = down_ff ? (modifier_ff | mod_mask_ff) : (modifier_ff & ~mod_mask_ff);
      end else if (!err_ff) begin
         if (down_ff) begin
            if (!held && full) begin
               // drop the oldest key, append the new one
               for (int i = 0; i < KEY_SLOTS; i++) begin
                  slot_in[i] = (i == KEY_SLOTS - 1) ? usage_ff : slot_above[i];
               end
            end else if (!held) begin
               for (int i = 0; i < KEY_SLOTS; i++) begin
                  if (count_ff == CW'(i)) begin
                     slot_in[i] = usage_ff;
                  end
               end
               count_in = count_ff + CW'(1);
            end
         end else if (held) begin
            // remove the key and close the gap
            for (int i = 0; i < KEY_SLOTS; i++) begin
               if (at_or_above[i]) begin
                  slot_in[i] = slot_above[i];
               end
            end
            count_in = count_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modifier_ff <= 8'h00;
         count_ff    <= '0;
         for (int i = 0; i < KEY_SLOTS; i++) begin
            slot_ff[i] <= 8'h00;
         end
      end else if (cmd.apply) begin
         modifier_ff <= modifier_in;
         count_ff    <= count_in;
         slot_ff     <= slot_in;
      end
   end

   always_comb begin
      differs = (modifier_ff != sent_mod_ff);
      for (int i = 0; i < KEY_SLOTS; i++) begin
         differs = differs | (slot_ff[i] != sent_slot_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sent_mod_ff <= SENT_MOD_RESET;
         for (int i = 0; i < KEY_SLOTS; i++) begin
            sent_slot_ff[i] <= 8'h00;
         end
      end else if (cmd.report && !err_ff && differs) begin
         sent_mod_ff  <= modifier_ff;
         sent_slot_ff <= slot_ff;
      end
   end

   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.report) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.report) begin
         rsp_status_ff <= err_ff ? STATUS_UNSUPPORTED : STATUS_OK;
         rsp_report_ff <= !err_ff && differs;
         rsp_mod_ff    <= modifier_ff;
      end
   end

   for (genvar g = 0; g < OUT_SLOTS; g++) begin : g_out
      if (g < KEY_SLOTS) begin : g_used
         always_ff @(posedge clock) begin
            if (cmd.report) begin
               rsp_slot_ff[g] <= slot_ff[g];
            end
         end
      end else begin : g_unused
         assign rsp_slot_ff[g] = 8'h00;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_report_valid  = rsp_report_ff;
   assign rsp_modifier_bits = rsp_mod_ff;
   assign rsp_key_slots     = rsp_slot_ff;

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(KEY_SLOTS))
      else $error("key count beyond slot count");

   a_first_slot_tracks_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) == (slot_ff[0] == 8'h00))
      else $error("slots not compacted");

   a_error_no_report: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STATUS_UNSUPPORTED) |-> !rsp_report_ff)
      else $error("report flagged on unsupported code");

endmodule

### rtl/scancode_to_hid_keyboard_report.sv
// ----------------------------------------------------------------------------
// scancode_to_hid_keyboard_report
// Set-1 scan code events to HID boot keyboard report state, with change
// detection against the last report sent.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall): one item is a key event (cmd 0,
//   scan code with E0 and down flags) or a release-all command (cmd 1).
//   Response channel (rsp_valid / rsp_stall): one item per request giving
//   status, report_valid, the modifier byte and the first six key slots.
//   csr_wr_en / csr_wr_data write the report identifier; write it only
//   while the block is idle.
// Flow:
//   An item passes in order through accept, table lookup, slot update and
//   report compare. The result goes from the capture register through the
//   lookup and slot registers into the output register. A new item is
//   accepted only after the last one has left the report stage, since the
//   single sequencer walks each item through the shared slot datapath.
// Reset:
//   Clears modifiers and slots, sets the report identifier to 1 and marks
//   the last-sent modifiers as all ones, so the first valid event flags a
//   report.
// Stall:
//   A held result stays in the output register; the next item may still be
//   accepted and worked, and waits at the report stage until the register
//   frees.
// ----------------------------------------------------------------------------
module scancode_to_hid_keyboard_report
   import sc2hid_pkg::*;
#(
   parameter int KEY_SLOTS = KEY_SLOTS_DEFAULT
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_cmd,
   input  logic [7:0] req_scan_code,
   input  logic       req_is_extended,
   input  logic       req_is_down,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_status,
   output logic       rsp_report_valid,
   output logic [7:0] rsp_modifier_bits,
   output logic [7:0] rsp_key_slot_0,
   output logic [7:0] rsp_key_slot_1,
   output logic [7:0] rsp_key_slot_2,
   output logic [7:0] rsp_key_slot_3,
   output logic [7:0] rsp_key_slot_4,
   output logic [7:0] rsp_key_slot_5,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   dp_cmd_type cmd;
   dp_sts_type sts;
   logic [7:0] key_slots [OUT_SLOTS];

   // Report identifier: framing byte for the host side, held here only
   logic [7:0] report_id_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         report_id_ff <= REPORT_ID_RESET;
      end else if (csr_wr_en) begin
         report_id_ff <= csr_wr_data;
      end
   end

   // Sequencer: one item in flight, four steps each
   sc2hid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Slot store, change detection and output register
   sc2hid_dpath #(
      .KEY_SLOTS (KEY_SLOTS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_cmd           (req_cmd),
      .req_scan_code     (req_scan_code),
      .req_is_extended   (req_is_extended),
      .req_is_down       (req_is_down),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_report_valid  (rsp_report_valid),
      .rsp_modifier_bits (rsp_modifier_bits),
      .rsp_key_slots     (key_slots)
   );

   // Fan the slot array out to the per-slot ports
   assign rsp_key_slot_0 = key_slots[0];
   assign rsp_key_slot_1 = key_slots[1];
   assign rsp_key_slot_2 = key_slots[2];
   assign rsp_key_slot_3 = key_slots[3];
   assign rsp_key_slot_4 = key_slots[4];
   assign rsp_key_slot_5 = key_slots[5];

endmodule
